// File: design/nrs_pkg.sv
// ---------------------------------------------------------------------------
// nrs_pkg
// Shared constants and types of the nearest road segment top-k block.
// ---------------------------------------------------------------------------
package nrs_pkg;

  localparam int TABLE_DEPTH_DEF = 8;
  localparam int COORD_BITS_DEF  = 30;
  localparam int FEAT_W          = 32;
  localparam int SEG_W           = 16;
  localparam int MAX_EMIT        = 8;
  localparam int CNT_W           = 4;

  localparam logic [SEG_W-1:0] SEG_MAX = {SEG_W{1'b1}};

  localparam logic [1:0] REG_QUERY_X = 2'd0;
  localparam logic [1:0] REG_QUERY_Y = 2'd1;
  localparam logic [1:0] REG_MAX_RES = 2'd2;

  localparam logic OP_SEGMENT = 1'b0;
  localparam logic OP_FLUSH   = 1'b1;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clr;
  } cell_ctl_t;

endpackage

// File: design/nrs_cell.sv
// ---------------------------------------------------------------------------
// nrs_cell
// One entry of the sorted candidate chain: insert from the left, shift
// toward the head on emit.
// ---------------------------------------------------------------------------
module nrs_cell
  import nrs_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cell_ctl_t                    ctl,
  input  logic [2*COORD_BITS+1:0]      new_dist,
  input  logic [FEAT_W-1:0]            new_feat,
  input  logic [SEG_W-1:0]             new_seg,
  input  logic signed [COORD_BITS-1:0] new_x,
  input  logic signed [COORD_BITS-1:0] new_y,
  input  logic                         new_ow,
  input  logic                         left_keep,
  input  logic                         left_valid,
  input  logic [2*COORD_BITS+1:0]      left_dist,
  input  logic [FEAT_W-1:0]            left_feat,
  input  logic [SEG_W-1:0]             left_seg,
  input  logic signed [COORD_BITS-1:0] left_x,
  input  logic signed [COORD_BITS-1:0] left_y,
  input  logic                         left_ow,
  input  logic                         right_valid,
  input  logic [2*COORD_BITS+1:0]      right_dist,
  input  logic [FEAT_W-1:0]            right_feat,
  input  logic [SEG_W-1:0]             right_seg,
  input  logic signed [COORD_BITS-1:0] right_x,
  input  logic signed [COORD_BITS-1:0] right_y,
  input  logic                         right_ow,
  output logic                         valid,
  output logic                         keep,
  output logic [2*COORD_BITS+1:0]      distance,
  output logic [FEAT_W-1:0]            feat,
  output logic [SEG_W-1:0]             seg,
  output logic signed [COORD_BITS-1:0] x,
  output logic signed [COORD_BITS-1:0] y,
  output logic                         ow
);

  // equal distances stay ahead of the new item
  assign keep = valid && (distance <= new_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins && !keep) begin
      valid <= left_keep ? 1'b1 : left_valid;
    end else if (ctl.shift) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins && !keep) begin
      if (left_keep) begin
        distance <= new_dist;
        feat     <= new_feat;
        seg      <= new_seg;
        x        <= new_x;
        y        <= new_y;
        ow       <= new_ow;
      end else begin
        distance <= left_dist;
        feat     <= left_feat;
        seg      <= left_seg;
        x        <= left_x;
        y        <= left_y;
        ow       <= left_ow;
      end
    end else if (ctl.shift) begin
      distance <= right_dist;
      feat     <= right_feat;
      seg      <= right_seg;
      x        <= right_x;
      y        <= right_y;
      ow       <= right_ow;
    end
  end

endmodule

// File: design/nrs_geom.sv
// ---------------------------------------------------------------------------
// nrs_geom
// Clamped projection of the query point onto one segment and the squared
// distance, on one shared multiplier and a two-lane serial divider.
// ---------------------------------------------------------------------------
module nrs_geom
  import nrs_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [COORD_BITS-1:0] qx,
  input  logic signed [COORD_BITS-1:0] qy,
  input  logic signed [COORD_BITS-1:0] sx_in,
  input  logic signed [COORD_BITS-1:0] sy_in,
  input  logic signed [COORD_BITS-1:0] ex_in,
  input  logic signed [COORD_BITS-1:0] ey_in,
  output logic                         done,
  output logic signed [COORD_BITS-1:0] px,
  output logic signed [COORD_BITS-1:0] py,
  output logic [2*COORD_BITS+1:0]      distance
);

  localparam int CW   = COORD_BITS;
  localparam int DW   = 2 * CW + 2;
  localparam int DOTW = DW + 1;
  localparam int RW   = DW + 2;
  localparam int CNTW = $clog2(CW + 1);

  localparam logic [2:0] G_IDLE = 3'd0;
  localparam logic [2:0] G_MUL  = 3'd1;
  localparam logic [2:0] G_DEC  = 3'd2;
  localparam logic [2:0] G_DIV  = 3'd3;
  localparam logic [2:0] G_POS  = 3'd4;
  localparam logic [2:0] G_OFS  = 3'd5;
  localparam logic [2:0] G_SQ   = 3'd6;

  logic [2:0]             state;
  logic [CNTW-1:0]        cnt;
  logic signed [CW-1:0]   sx, sy, ex, ey;
  logic signed [CW:0]     dx, dy, vx, vy, ox, oy;
  logic signed [DW-1:0]   prod;
  logic signed [DOTW-1:0] dot;
  logic [DW-1:0]          len2;
  logic signed [CW:0]     ma, mb;
  logic [CW:0]            mag [2];
  logic [RW-1:0]          rem [2];
  logic [CW:0]            quo [2];
  logic [RW-1:0]          rem_next [2];
  logic [CW:0]            quo_next [2];
  logic                   neg [2];
  logic [RW-1:0]          dot_ext, l1, l2;

  always_comb begin
    ma = dx;
    mb = vx;
    if (state == G_MUL) begin
      unique case (cnt[1:0])
        2'd0: begin ma = dx; mb = vx; end
        2'd1: begin ma = dy; mb = vy; end
        2'd2: begin ma = dx; mb = dx; end
        default: begin ma = dy; mb = dy; end
      endcase
    end else if (state == G_SQ) begin
      if (cnt[0]) begin
        ma = oy;
        mb = oy;
      end else begin
        ma = ox;
        mb = ox;
      end
    end
  end

  // radix-2 long division of mag*dot by len2; remainder stays below len2
  assign dot_ext = {2'b00, dot[DW-1:0]};
  assign l1      = {2'b00, len2};
  assign l2      = {1'b0, len2, 1'b0};

  always_comb begin
    logic [RW-1:0] t;
    for (int k = 0; k < 2; k++) begin
      t = {rem[k][RW-2:0], 1'b0} + (mag[k][CW] ? dot_ext : '0);
      if (t >= l2) begin
        rem_next[k] = t - l2;
        quo_next[k] = {quo[k][CW-1:0], 1'b0} + {{(CW-1){1'b0}}, 2'd2};
      end else if (t >= l1) begin
        rem_next[k] = t - l1;
        quo_next[k] = {quo[k][CW-1:0], 1'b1};
      end else begin
        rem_next[k] = t;
        quo_next[k] = {quo[k][CW-1:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        G_IDLE: begin
          if (start) begin
            state <= G_MUL;
            cnt   <= '0;
          end
        end
        G_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(4)) state <= G_DEC;
        end
        G_DEC: begin
          cnt <= '0;
          if (len2 == '0 || dot[DOTW-1] || dot == '0) state <= G_OFS;
          else if ($unsigned(dot) >= {1'b0, len2}) state <= G_OFS;
          else state <= G_DIV;
        end
        G_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(CW)) state <= G_POS;
        end
        G_POS: state <= G_OFS;
        G_OFS: begin
          state <= G_SQ;
          cnt   <= '0;
        end
        G_SQ: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(2)) begin
            state <= G_IDLE;
            done  <= 1'b1;
          end
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      G_IDLE: begin
        if (start) begin
          sx <= sx_in;
          sy <= sy_in;
          ex <= ex_in;
          ey <= ey_in;
          dx <= {ex_in[CW-1], ex_in} - {sx_in[CW-1], sx_in};
          dy <= {ey_in[CW-1], ey_in} - {sy_in[CW-1], sy_in};
          vx <= {qx[CW-1], qx} - {sx_in[CW-1], sx_in};
          vy <= {qy[CW-1], qy} - {sy_in[CW-1], sy_in};
        end
      end
      G_MUL: begin
        unique case (cnt[2:0])
          3'd1: dot <= {prod[DW-1], prod};
          3'd2: dot <= dot + {prod[DW-1], prod};
          3'd3: len2 <= prod;
          3'd4: len2 <= len2 + prod;
          default: ;
        endcase
      end
      G_DEC: begin
        if (len2 == '0 || dot[DOTW-1] || dot == '0) begin
          px <= sx;
          py <= sy;
        end else if ($unsigned(dot) >= {1'b0, len2}) begin
          px <= ex;
          py <= ey;
        end
        mag[0] <= dx[CW] ? -dx : dx;
        mag[1] <= dy[CW] ? -dy : dy;
        neg[0] <= dx[CW];
        neg[1] <= dy[CW];
        rem[0] <= '0;
        rem[1] <= '0;
        quo[0] <= '0;
        quo[1] <= '0;
      end
      G_DIV: begin
        for (int k = 0; k < 2; k++) begin
          rem[k] <= rem_next[k];
          quo[k] <= quo_next[k];
          mag[k] <= {mag[k][CW-1:0], 1'b0};
        end
      end
      G_POS: begin
        px <= neg[0] ? sx - quo[0][CW-1:0] : sx + quo[0][CW-1:0];
        py <= neg[1] ? sy - quo[1][CW-1:0] : sy + quo[1][CW-1:0];
      end
      G_OFS: begin
        ox <= {qx[CW-1], qx} - {px[CW-1], px};
        oy <= {qy[CW-1], qy} - {py[CW-1], py};
      end
      G_SQ: begin
        if (cnt == CNTW'(1)) distance <= prod;
        else if (cnt == CNTW'(2)) distance <= distance + prod;
      end
      default: ;
    endcase
  end

endmodule

// File: design/nearest_road_segment_top_k_top.sv
// ---------------------------------------------------------------------------
// nearest_road_segment_top_k_top
// Nearest segment per road feature against a query point, kept in a sorted
// chain of candidate cells and emitted on flush.
// ---------------------------------------------------------------------------
// One item at a time. A usable segment's time from accept to the next accept is
// set by the serial divider of the projection, one multiplier bit per cycle for
// both axes; a segment clamped to an end point skips the divider, and an unusable
// one skips the projection. Closing a feature inserts its candidate, if it has one,
// into the chain: all cells update together, the cells behind the insert point
// moving one place back. A flush moves one result per cycle out of the head cell
// as the output side takes them, then empties the chain.
module nearest_road_segment_top_k_top
  import nrs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         op,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic [FEAT_W-1:0]            feature_id,
  input  logic                         usable,
  input  logic                         one_way,
  input  logic                         last_of_feature,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [FEAT_W-1:0]            out_feature,
  output logic                         out_forward,
  output logic [SEG_W-1:0]             out_segment,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic                         out_last
);

  localparam int CW = COORD_BITS;
  localparam int DW = 2 * CW + 2;
  localparam int D  = TABLE_DEPTH;

  localparam logic [2:0] T_IDLE  = 3'd0;
  localparam logic [2:0] T_GEOM  = 3'd1;
  localparam logic [2:0] T_UPD   = 3'd2;
  localparam logic [2:0] T_CLOSE = 3'd3;
  localparam logic [2:0] T_EMIT  = 3'd4;

  logic [2:0]           state;
  logic signed [CW-1:0] query_x, query_y;
  logic [CNT_W-1:0]     max_res;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     emit_n;
  logic                 rev;

  logic [FEAT_W-1:0]    cur_feat;
  logic                 cur_usable, cur_ow, cur_last;

  logic [SEG_W-1:0]     segment_counter;
  logic                 best_found;
  logic [DW-1:0]        best_distance;
  logic [SEG_W-1:0]     best_segment;
  logic signed [CW-1:0] best_point_x, best_point_y;
  logic                 best_one_way;
  logic [FEAT_W-1:0]    best_feature;

  logic                 geom_start, geom_done;
  logic signed [CW-1:0] geom_px, geom_py;
  logic [DW-1:0]        geom_dist;

  logic                 accept;
  logic                 out_load;
  cell_ctl_t            ctl;

  logic [DW-1:0]        c_dist [D];
  logic [FEAT_W-1:0]    c_feat [D];
  logic [SEG_W-1:0]     c_seg  [D];
  logic signed [CW-1:0] c_x    [D];
  logic signed [CW-1:0] c_y    [D];
  logic                 c_ow   [D];
  logic                 c_valid[D];
  logic                 c_keep [D];
  logic                 head_next_valid;

  assign in_stall = (state != T_IDLE);
  assign accept   = in_valid && !in_stall;
  assign limit    = (max_res > CNT_W'(MAX_EMIT)) ? CNT_W'(MAX_EMIT) : max_res;
  assign geom_start = accept && (op == OP_SEGMENT) && usable;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x <= '0;
      query_y <= '0;
      max_res <= CNT_W'(MAX_EMIT);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_QUERY_X: query_x <= cfg_data;
        REG_QUERY_Y: query_y <= cfg_data;
        REG_MAX_RES: max_res <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  nrs_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk      (clk),
    .rst      (rst),
    .start    (geom_start),
    .qx       (query_x),
    .qy       (query_y),
    .sx_in    (start_x),
    .sy_in    (start_y),
    .ex_in    (end_x),
    .ey_in    (end_y),
    .done     (geom_done),
    .px       (geom_px),
    .py       (geom_py),
    .distance (geom_dist)
  );

  // head of the chain is cell 0
  generate
    if (D > 1) begin : g_next
      assign head_next_valid = c_valid[1];
    end else begin : g_nonext
      assign head_next_valid = 1'b0;
    end
  endgenerate

  always_comb begin
    ctl      = '0;
    out_load = 1'b0;
    if (state == T_CLOSE) begin
      ctl.ins = best_found;
    end else if (state == T_EMIT) begin
      if (!c_valid[0] || emit_n == limit) begin
        ctl.clr = 1'b1;
      end else if (!out_valid || !out_stall) begin
        out_load  = 1'b1;
        ctl.shift = rev || c_ow[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= T_IDLE;
      emit_n          <= '0;
      rev             <= 1'b0;
      segment_counter <= '0;
      best_found      <= 1'b0;
      best_distance   <= '1;
      best_segment    <= '0;
      best_point_x    <= '0;
      best_point_y    <= '0;
      best_one_way    <= 1'b0;
      best_feature    <= '0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            emit_n <= '0;
            rev    <= 1'b0;
            if (op == OP_FLUSH) state <= T_EMIT;
            else if (usable) state <= T_GEOM;
            else state <= T_UPD;
          end
        end
        T_GEOM: begin
          if (geom_done) state <= T_UPD;
        end
        T_UPD: begin
          if (cur_usable && (!best_found || geom_dist < best_distance)) begin
            best_found    <= 1'b1;
            best_distance <= geom_dist;
            best_segment  <= segment_counter;
            best_point_x  <= geom_px;
            best_point_y  <= geom_py;
            best_one_way  <= cur_ow;
            best_feature  <= cur_feat;
          end
          if (segment_counter != SEG_MAX) segment_counter <= segment_counter + 1'b1;
          state <= cur_last ? T_CLOSE : T_IDLE;
        end
        T_CLOSE: begin
          segment_counter <= '0;
          best_found      <= 1'b0;
          best_distance   <= '1;
          best_segment    <= '0;
          best_point_x    <= '0;
          best_point_y    <= '0;
          best_one_way    <= 1'b0;
          best_feature    <= '0;
          state           <= T_IDLE;
        end
        T_EMIT: begin
          if (ctl.clr) begin
            state <= T_IDLE;
          end else if (out_load) begin
            emit_n <= emit_n + 1'b1;
            rev    <= !(rev || c_ow[0]);
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_feat   <= feature_id;
      cur_usable <= usable;
      cur_ow     <= one_way;
      cur_last   <= last_of_feature;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_feature <= c_feat[0];
      out_forward <= !rev;
      out_segment <= c_seg[0];
      out_x       <= c_x[0];
      out_y       <= c_y[0];
      out_last    <= (emit_n + 1'b1 == limit) ||
                     (rev ? !head_next_valid : (c_ow[0] && !head_next_valid));
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < D; gi++) begin : g_cell
      logic                 lk, lv, rv, low, row;
      logic [DW-1:0]        ld, rd;
      logic [FEAT_W-1:0]    lf, rf;
      logic [SEG_W-1:0]     ls, rs;
      logic signed [CW-1:0] lx, ly, rx, ry;

      if (gi == 0) begin : g_left0
        assign lk  = 1'b1;
        assign lv  = 1'b0;
        assign ld  = best_distance;
        assign lf  = best_feature;
        assign ls  = best_segment;
        assign lx  = best_point_x;
        assign ly  = best_point_y;
        assign low = best_one_way;
      end else begin : g_left
        assign lk  = c_keep[gi-1];
        assign lv  = c_valid[gi-1];
        assign ld  = c_dist[gi-1];
        assign lf  = c_feat[gi-1];
        assign ls  = c_seg[gi-1];
        assign lx  = c_x[gi-1];
        assign ly  = c_y[gi-1];
        assign low = c_ow[gi-1];
      end

      if (gi == D - 1) begin : g_rightn
        assign rv  = 1'b0;
        assign rd  = c_dist[gi];
        assign rf  = c_feat[gi];
        assign rs  = c_seg[gi];
        assign rx  = c_x[gi];
        assign ry  = c_y[gi];
        assign row = c_ow[gi];
      end else begin : g_right
        assign rv  = c_valid[gi+1];
        assign rd  = c_dist[gi+1];
        assign rf  = c_feat[gi+1];
        assign rs  = c_seg[gi+1];
        assign rx  = c_x[gi+1];
        assign ry  = c_y[gi+1];
        assign row = c_ow[gi+1];
      end

      nrs_cell #(.COORD_BITS(COORD_BITS)) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .new_dist    (best_distance),
        .new_feat    (best_feature),
        .new_seg     (best_segment),
        .new_x       (best_point_x),
        .new_y       (best_point_y),
        .new_ow      (best_one_way),
        .left_keep   (lk),
        .left_valid  (lv),
        .left_dist   (ld),
        .left_feat   (lf),
        .left_seg    (ls),
        .left_x      (lx),
        .left_y      (ly),
        .left_ow     (low),
        .right_valid (rv),
        .right_dist  (rd),
        .right_feat  (rf),
        .right_seg   (rs),
        .right_x     (rx),
        .right_y     (ry),
        .right_ow    (row),
        .valid       (c_valid[gi]),
        .keep        (c_keep[gi]),
        .distance    (c_dist[gi]),
        .feat        (c_feat[gi]),
        .seg         (c_seg[gi]),
        .x           (c_x[gi]),
        .y           (c_y[gi]),
        .ow          (c_ow[gi])
      );
    end
  endgenerate

endmodule

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest road segment top-k block. Streams
// feature polylines and flushes under random gaps and output stalls, checks
// each flushed result against an in-bench projection and candidate table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import nrs_pkg::*;
;

  localparam int CB        = COORD_BITS_DEF;
  localparam int DEPTH     = TABLE_DEPTH_DEF;
  localparam int LIMIT     = 2000000;
  localparam int DRAIN_CYC = 80;

  typedef struct {
    logic          op;
    logic [CB-1:0] sx, sy, ex, ey;
    logic [31:0]   fid;
    logic          usable, ow, lastf;
    bit            hold;    // wait for all results before this item
    bit            nogap;
  } road_item_t;

  typedef struct {
    logic [31:0]   feat;
    logic          fwd;
    logic [15:0]   seg;
    logic [CB-1:0] x, y;
    logic          last;
  } road_result_t;

  typedef struct {
    longint unsigned distance;
    logic [31:0]     feat;
    int unsigned     seg;
    longint          px, py;
    bit              ow;
  } cand_t;

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = REG_QUERY_X;
  logic [CB-1:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic op = OP_SEGMENT;
  logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic [31:0] feature_id = '0;
  logic usable = 0, one_way = 0, last_of_feature = 0;
  logic out_valid, out_stall = 0;
  logic [31:0] out_feature;
  logic out_forward, out_last;
  logic [15:0] out_segment;
  logic signed [CB-1:0] out_x, out_y;

  nearest_road_segment_top_k_top u_top (.*);

  initial forever #2 clk = ~clk;

  road_item_t   pending[$];
  road_result_t flushed_results[$];
  int mismatches = 0;
  int cycles = 0;
  bit burst = 0;

  // predictor state
  longint q_x = 0, q_y = 0;
  int unsigned max_want = 8;
  int unsigned seg_count = 0;
  bit best_found = 0;
  cand_t best;
  cand_t table_c[DEPTH];
  int unsigned cand_count = 0;

  function automatic longint sext(logic [CB-1:0] v);
    longint r;
    r = $signed(v);
    return r;
  endfunction

  function automatic longint along(longint base, longint delta, longint dot, longint len2);
    logic [127:0] mag, prod, q;
    mag = (delta < 0) ? 128'(-delta) : 128'(delta);
    prod = mag * 128'(dot);
    q = prod / 128'(len2);
    return (delta < 0) ? base - longint'(q[63:0]) : base + longint'(q[63:0]);
  endfunction

  function automatic void clear_best();
    seg_count = 0;
    best_found = 0;
    best = '{distance: 64'h3FFF_FFFF_FFFF_FFFF, feat: 0, seg: 0, px: 0, py: 0, ow: 0};
  endfunction

  function automatic void insert_best();
    int unsigned pos, top;
    pos = 0;
    while (pos < cand_count && table_c[pos].distance <= best.distance) pos++;
    if (pos >= DEPTH) return;
    top = (cand_count < DEPTH) ? cand_count : DEPTH - 1;
    for (int unsigned i = top; i > pos; i--) table_c[i] = table_c[i-1];
    table_c[pos] = best;
    if (cand_count < DEPTH) cand_count++;
  endfunction

  function automatic road_result_t mk_res(int unsigned i, bit fwd);
    road_result_t r;
    r.feat = table_c[i].feat;
    r.fwd = fwd;
    r.seg = table_c[i].seg[15:0];
    r.x = table_c[i].px[CB-1:0];
    r.y = table_c[i].py[CB-1:0];
    r.last = 0;
    return r;
  endfunction

  function automatic void predict_item(road_item_t it);
    longint sx, sy, ex, ey, dx, dy, vx, vy, dot, len2, px, py, ox, oy;
    longint unsigned sq_dist;
    int unsigned n, lim;
    if (it.op == OP_FLUSH) begin
      n = 0;
      lim = (max_want > MAX_EMIT) ? MAX_EMIT : max_want;
      for (int unsigned i = 0; i < cand_count && n < lim; i++) begin
        flushed_results = {flushed_results, mk_res(i, 1)}; n++;
        if (n >= lim) break;
        if (!table_c[i].ow) begin
          flushed_results = {flushed_results, mk_res(i, 0)}; n++;
        end
      end
      if (n > 0) flushed_results[$].last = 1;
      cand_count = 0;
      return;
    end
    if (it.usable) begin
      sx = sext(it.sx); sy = sext(it.sy); ex = sext(it.ex); ey = sext(it.ey);
      dx = ex - sx; dy = ey - sy; vx = q_x - sx; vy = q_y - sy;
      dot = dx * vx + dy * vy;
      len2 = dx * dx + dy * dy;
      if (len2 == 0 || dot <= 0) begin
        px = sx; py = sy;
      end else if (dot >= len2) begin
        px = ex; py = ey;
      end else begin
        px = along(sx, dx, dot, len2);
        py = along(sy, dy, dot, len2);
      end
      ox = q_x - px; oy = q_y - py;
      sq_dist = ox * ox + oy * oy;
      if (!best_found || sq_dist < best.distance) begin
        best_found = 1;
        best = '{distance: sq_dist, feat: it.fid, seg: seg_count, px: px, py: py, ow: it.ow};
      end
    end
    if (seg_count < 65535) seg_count++;
    if (it.lastf) begin
      if (best_found) insert_best();
      clear_best();
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // input side
  int in_gap = 0;
  always @(posedge clk) begin
    road_item_t nxt;
    bit present;
    if (!rst) begin
      present = in_valid;
      if (in_valid && !in_stall) begin
        predict_item(pending.pop_front());
        in_gap = pending.size() > 0 && pending[0].nogap ? 0 : pick_gap();
        present = 0;
      end
      if (!present) begin
        if (in_gap > 0) in_gap--;
        else if (pending.size() > 0 &&
                 !(pending[0].hold && flushed_results.size() > 0)) begin
          present = 1;
          nxt = pending[0];
          op <= nxt.op;
          start_x <= nxt.sx; start_y <= nxt.sy; end_x <= nxt.ex; end_y <= nxt.ey;
          feature_id <= nxt.fid;
          usable <= nxt.usable; one_way <= nxt.ow; last_of_feature <= nxt.lastf;
        end
      end
      in_valid <= present;
    end
  end

  // output side
  int out_gap = 0;
  always @(posedge clk) begin
    road_result_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (flushed_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result feature %h", out_feature);
        end else begin
          e = flushed_results.pop_front();
          if (out_feature !== e.feat || out_forward !== e.fwd || out_segment !== e.seg ||
              out_x !== e.x || out_y !== e.y || out_last !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp f=%h fw=%b s=%0d x=%h y=%h l=%b",
                       e.feat, e.fwd, e.seg, e.x, e.y, e.last,
                       " got f=%h fw=%b s=%0d x=%h y=%h l=%b",
                       out_feature, out_forward, out_segment, out_x, out_y, out_last);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1;
      end else begin
        out_gap = burst ? 0 : pick_gap();
        out_stall <= (out_gap > 0);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("nearest_road_segment_top_k_top: mismatch");
      $finish;
    end
  end

  function automatic void add(logic o, logic [CB-1:0] sx, sy, ex, ey, logic [31:0] fid,
                              logic u, w, l, bit hold = 0);
    road_item_t it;
    it = '{op: o, sx: sx, sy: sy, ex: ex, ey: ey, fid: fid, usable: u, ow: w,
           lastf: l, hold: hold, nogap: 0};
    pending = {pending, it};
  endfunction

  function automatic logic [CB-1:0] near_q(longint c);
    longint span;
    span = longint'(1) << $urandom_range(2, CB - 1);
    return CB'(c + longint'($urandom_range(0, 32'hFFFF_FFFF)) % span - span / 2);
  endfunction

  function automatic void rand_feature();
    int nseg;
    bit w, wide, dup;
    logic [31:0] fid;
    logic [CB-1:0] a, b, c, d;
    nseg = $urandom_range(1, 5);
    w = $urandom_range(0, 1);
    fid = $urandom();
    for (int i = 0; i < nseg; i++) begin
      wide = ($urandom_range(0, 3) == 0);
      dup = (i > 0 && $urandom_range(0, 5) == 0);
      if (!dup) begin
        a = wide ? CB'($urandom()) : near_q(q_x);
        b = wide ? CB'($urandom()) : near_q(q_y);
        c = wide ? CB'($urandom()) : near_q(q_x);
        d = wide ? CB'($urandom()) : near_q(q_y);
      end
      add(OP_SEGMENT, a, b, c, d, fid, $urandom_range(0, 7) != 0, w, i == nseg - 1);
      if ($urandom_range(0, 30) == 0)
        add(OP_FLUSH, CB'($urandom()), CB'($urandom()), CB'($urandom()), CB'($urandom()),
            $urandom(), $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endfunction

  function automatic void rand_phase(int n);
    int start;
    start = pending.size();
    while (pending.size() - start < n) begin
      if ($urandom_range(0, 9) == 0)
        add(OP_SEGMENT, CB'($urandom()), CB'($urandom()), CB'($urandom()), CB'($urandom()),
            $urandom(), $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
      else rand_feature();
      if ($urandom_range(0, 4) == 0)
        add(OP_FLUSH, CB'($urandom()), CB'($urandom()), CB'($urandom()), CB'($urandom()),
            $urandom(), $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
            $urandom_range(0, 5) == 0);
    end
    add(OP_FLUSH, '0, '0, '0, '0, '0, 0, 0, 0);
  endfunction

  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || flushed_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CB-1:0] val);
    @(posedge clk);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_QUERY_X: q_x = sext(val);
      REG_QUERY_Y: q_y = sext(val);
      default:     max_want = val[3:0];
    endcase
  endtask

  localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};

  initial begin
    clear_best();
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: default query at origin, 8 results
    add(OP_FLUSH, '0, '0, '0, '0, '0, 0, 0, 0);                       // empty table
    add(OP_SEGMENT, CMIN, CMIN, CMAX, CMAX, 32'hFFFF_FFFF, 1, 0, 1);   // extremes
    add(OP_SEGMENT, 30'd5, 30'd5, 30'd5, 30'd5, 32'h1, 1, 1, 0);       // zero length
    add(OP_FLUSH, CMAX, CMIN, CMAX, CMIN, 32'hA5A5_A5A5, 1, 1, 1);     // mid feature
    add(OP_SEGMENT, 30'd3, 30'd4, 30'd10, 30'd10, 32'h1, 1, 0, 0);     // clamped to start
    add(OP_SEGMENT, -30'sd10, 30'd5, -30'sd4, 30'd5, 32'h1, 1, 0, 0);  // clamped to end
    add(OP_SEGMENT, -30'sd7, 30'd3, 30'd9, -30'sd5, 32'h1, 1, 0, 1);   // interior
    add(OP_SEGMENT, 30'd1, 30'd0, 30'd1, 30'd0, 32'h2, 0, 0, 0);       // unusable
    add(OP_SEGMENT, 30'd9, 30'd0, 30'd9, 30'd0, 32'h2, 0, 0, 1);
    for (int i = 0; i < 10; i++)                                       // overfill, ties
      add(OP_SEGMENT, CB'(i % 3), 30'd2, CB'(i % 3), 30'd2, 32'h100 + i, 1, i % 2, 1);
    add(OP_FLUSH, '0, '0, '0, '0, '0, 0, 0, 0, 1);
    add(OP_SEGMENT, 30'd4, 30'd0, 30'd4, 30'd0, 32'h77, 1, 0, 1);
    add(OP_FLUSH, '0, '0, '0, '0, '0, 0, 0, 0);
    wait_idle();

    burst = 1;
    rand_phase(30);
    wait_idle();
    burst = 0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_QUERY_X, CMAX); write_reg(REG_QUERY_Y, CMIN);
                 write_reg(REG_MAX_RES, 4'd1); end
        1: begin write_reg(REG_QUERY_X, CMIN); write_reg(REG_QUERY_Y, CMAX);
                 write_reg(REG_MAX_RES, 4'd15); end
        2: begin write_reg(REG_MAX_RES, 4'd0); end
        3: begin write_reg(REG_QUERY_X, CB'($urandom())); write_reg(REG_QUERY_Y, 30'd0);
                 write_reg(REG_MAX_RES, 4'd3); end
        4: begin write_reg(REG_QUERY_X, 30'd100); write_reg(REG_QUERY_Y, -30'sd100);
                 write_reg(REG_MAX_RES, 4'd8); end
        default: begin write_reg(REG_QUERY_Y, CB'($urandom()));
                 write_reg(REG_MAX_RES, CB'($urandom_range(9, 14))); end
      endcase
      @(posedge clk);
      cfg_write <= 0;
      burst = (ph == 4);
      rand_phase(ph == 2 ? 15 : 40);
      wait_idle();
    end

    if (mismatches == 0)
      $display("nearest_road_segment_top_k_top: match");
    else
      $display("nearest_road_segment_top_k_top: mismatch");
    $finish;
  end

endmodule

// File: sim.f
design/nrs_pkg.sv
design/nrs_cell.sv
design/nrs_geom.sv
design/nearest_road_segment_top_k_top.sv
verif/tb.sv
